// ----- src/vspc_pkg.sv -----
// ----------------------------------------------------------------------------
// vspc_pkg: shared types and constants
// Register indexes, configuration bundle, fixed-point constants and the
// coefficient lane helper used across the sample projection block.
// ----------------------------------------------------------------------------
package vspc_pkg;

	localparam int REG_IDX_W = 3;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_VIEW_X = 3'd0;
	localparam reg_idx_t REG_VIEW_Y = 3'd1;
	localparam reg_idx_t REG_VIEW_Z = 3'd2;
	localparam reg_idx_t REG_PROJ_X = 3'd3;
	localparam reg_idx_t REG_PROJ_Y = 3'd4;
	localparam reg_idx_t REG_PROJ_Z = 3'd5;
	localparam reg_idx_t REG_PROJ_W = 3'd6;
	localparam reg_idx_t REG_ASPECT = 3'd7;

	localparam logic [63:0] RST_VIEW_X = 64'h0000_0000_0000_4000;
	localparam logic [63:0] RST_VIEW_Y = 64'h0000_0000_4000_0000;
	localparam logic [63:0] RST_VIEW_Z = 64'h0000_4000_0000_0000;
	localparam logic [63:0] RST_PROJ_X = 64'h0000_0000_0000_1000;
	localparam logic [63:0] RST_PROJ_Y = 64'h0000_0000_1000_0000;
	localparam logic [63:0] RST_PROJ_Z = 64'h0000_1000_0000_0000;
	localparam logic [63:0] RST_PROJ_W = 64'h1000_0000_0000_0000;
	localparam logic [15:0] RST_ASPECT = 16'h1000;

	typedef struct packed {
		logic [63:0] view_x;
		logic [63:0] view_y;
		logic [63:0] view_z;
		logic [63:0] proj_x;
		logic [63:0] proj_y;
		logic [63:0] proj_z;
		logic [63:0] proj_w;
		logic [15:0] aspect;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Fade window in Q.8 view units
	localparam int FADE_NEAR_Q8 = -102400;
	localparam int FADE_FAR_Q8  = -128000;
	localparam int FADE_SPAN_Q8 = 25600;

	localparam int VIEW_ROUND   = 8192;
	localparam int VIEW_SHIFT   = 14;
	localparam int DIV_SCALE_SH = 13;
	localparam int ASPECT_ROUND = 2048;
	localparam int ASPECT_SHIFT = 12;
	localparam int QUOT_W       = 16;
	localparam int QUOT_CNT_W   = 4;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;
	localparam int QCNT_W       = 3;

	function automatic logic signed [15:0] lane(input logic [63:0] row, input logic [1:0] k);
		return row[{k, 4'b0000} +: 16];
	endfunction

endpackage

// ----- src/vspc_if.sv -----
// ----------------------------------------------------------------------------
// vspc_sample_if / vspc_result_if: stream channels
// Valid/ready channels for world samples in and screen samples out.
// ----------------------------------------------------------------------------
interface vspc_sample_if #(parameter int COORD_WIDTH = 24);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic [15:0]                   level_in;
	logic                          end_of_path;

	modport source (output valid, pos_x, pos_y, pos_z, level_in, end_of_path, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, level_in, end_of_path, output ready);
endinterface

interface vspc_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic [15:0]        level_out;
	logic               path_start;

	modport source (output valid, screen_x, screen_y, level_out, path_start, input ready);
	modport sink (input valid, screen_x, screen_y, level_out, path_start, output ready);
endinterface

// ----- src/vector_sample_project_clip.sv -----
// ----------------------------------------------------------------------------
// vector_sample_project_clip: world-to-screen projection of display samples
// Configuration registers, intake queue and transform sequencer.
// ----------------------------------------------------------------------------
// Each world sample is queued by the front end and processed one at a time by
// a sequencer that shares a single 17 x (COORD_WIDTH+10) multiplier and a
// 16-iteration restoring divider. A visible sample passes intake, 9 view
// terms on the multiplier, a fade check, 16 projection terms, a clip test,
// two divides for x/w and y/w (skipped when w is zero), the aspect product
// and output; inside the fade band it takes one extra divide by the fade
// span. A clipped sample stops after the clip test and a blanked one is
// dropped at intake. A stalled result output holds the sequencer in its
// output state. Four samples queue ahead of the sequencer and a finished
// result waits in an output register, so either side may stall without
// blocking the other.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no sample is in flight.
module vector_sample_project_clip #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	vspc_sample_if.sink                sample,
	vspc_result_if.source              result,
	input  logic                       cfg_we,
	input  logic [vspc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                cfg_data
);

	vspc_pkg::cfg_t cfg_q;

	// Queue handoff between intake and sequencer
	logic                          q_valid;
	logic                          q_pop;
	logic signed [COORD_WIDTH-1:0] q_pos_x;
	logic signed [COORD_WIDTH-1:0] q_pos_y;
	logic signed [COORD_WIDTH-1:0] q_pos_z;
	logic [15:0]                   q_level;
	logic                          q_eop;
	logic                          q_blank;

	// Hold configuration; load on a write, identity transforms after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_x <= vspc_pkg::RST_VIEW_X;
			cfg_q.view_y <= vspc_pkg::RST_VIEW_Y;
			cfg_q.view_z <= vspc_pkg::RST_VIEW_Z;
			cfg_q.proj_x <= vspc_pkg::RST_PROJ_X;
			cfg_q.proj_y <= vspc_pkg::RST_PROJ_Y;
			cfg_q.proj_z <= vspc_pkg::RST_PROJ_Z;
			cfg_q.proj_w <= vspc_pkg::RST_PROJ_W;
			cfg_q.aspect <= vspc_pkg::RST_ASPECT;
		end else if (cfg_we) begin
			case (cfg_index)
				vspc_pkg::REG_VIEW_X: cfg_q.view_x <= cfg_data;
				vspc_pkg::REG_VIEW_Y: cfg_q.view_y <= cfg_data;
				vspc_pkg::REG_VIEW_Z: cfg_q.view_z <= cfg_data;
				vspc_pkg::REG_PROJ_X: cfg_q.proj_x <= cfg_data;
				vspc_pkg::REG_PROJ_Y: cfg_q.proj_y <= cfg_data;
				vspc_pkg::REG_PROJ_Z: cfg_q.proj_z <= cfg_data;
				vspc_pkg::REG_PROJ_W: cfg_q.proj_w <= cfg_data;
				vspc_pkg::REG_ASPECT: cfg_q.aspect <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Accept transactions and mark blanked samples
	vspc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_pos_x (q_pos_x),
		.q_pos_y (q_pos_y),
		.q_pos_z (q_pos_z),
		.q_level (q_level),
		.q_eop   (q_eop),
		.q_blank (q_blank)
	);

	// Transform, clip, divide and emit one result transaction per visible sample
	vspc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_pos_x (q_pos_x),
		.q_pos_y (q_pos_y),
		.q_pos_z (q_pos_z),
		.q_level (q_level),
		.q_eop   (q_eop),
		.q_blank (q_blank),
		.result  (result)
	);

endmodule

// ----- src/vspc_front.sv -----
// ----------------------------------------------------------------------------
// vspc_front: sample intake
// Accepts samples, marks blanked ones and holds them in a short queue.
// ----------------------------------------------------------------------------
module vspc_front #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vspc_sample_if.sink                   sample,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic signed [COORD_WIDTH-1:0] q_pos_x,
	output logic signed [COORD_WIDTH-1:0] q_pos_y,
	output logic signed [COORD_WIDTH-1:0] q_pos_z,
	output logic [15:0]                   q_level,
	output logic                          q_eop,
	output logic                          q_blank
);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic [15:0]                   level;
		logic                          eop;
		logic                          blank;
	} entry_t;

	entry_t                      mem_q [vspc_pkg::QUEUE_DEPTH];
	logic [vspc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [vspc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [vspc_pkg::QCNT_W-1:0] count_q;
	logic                        push;
	logic                        pop;
	entry_t                      head;

	assign sample.ready = (count_q != vspc_pkg::QCNT_W'(vspc_pkg::QUEUE_DEPTH));
	assign push = sample.valid && sample.ready;
	assign q_valid = (count_q != '0);
	assign pop = q_pop && q_valid;

	assign head = mem_q[rd_ptr_q];
	assign q_pos_x = head.x;
	assign q_pos_y = head.y;
	assign q_pos_z = head.z;
	assign q_level = head.level;
	assign q_eop = head.eop;
	assign q_blank = head.blank;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{x: sample.pos_x, y: sample.pos_y, z: sample.pos_z,
				level: sample.level_in, eop: sample.end_of_path,
				blank: (sample.level_in == 16'd0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- src/vspc_div.sv -----
// ----------------------------------------------------------------------------
// vspc_div: iterative unsigned divider
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module vspc_div #(
	parameter int DW = 68
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [DW-1:0]                   num,
	input  logic [DW-1:0]                   den,
	output vspc_pkg::div_stat_t             stat,
	output logic [vspc_pkg::QUOT_W-1:0]     quot
);

	logic [DW-1:0]                       rem_q;
	logic [DW-1:0]                       den_q;
	logic [vspc_pkg::QUOT_W-1:0]         quot_q;
	logic [vspc_pkg::QUOT_CNT_W-1:0]     cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic                                fits;

	assign fits = (rem_q >= den_q);
	assign stat = '{busy: busy_q, done: done_q};
	assign quot = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den << (vspc_pkg::QUOT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) rem_q <= rem_q - den_q;
			quot_q <= {quot_q[vspc_pkg::QUOT_W-2:0], fits};
			den_q <= den_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= vspc_pkg::QUOT_CNT_W'(vspc_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

endmodule

// ----- src/vspc_back.sv -----
// ----------------------------------------------------------------------------
// vspc_back: transform sequencer
// Runs view transform, fade, projection, clip test, divide and aspect scale
// on one sample at a time over a shared multiplier and divider.
// ----------------------------------------------------------------------------
module vspc_back #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vspc_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic signed [COORD_WIDTH-1:0] q_pos_x,
	input  logic signed [COORD_WIDTH-1:0] q_pos_y,
	input  logic signed [COORD_WIDTH-1:0] q_pos_z,
	input  logic [15:0]                   q_level,
	input  logic                          q_eop,
	input  logic                          q_blank,
	vspc_result_if.source                 result
);

	localparam int VW = COORD_WIDTH + 10;
	localparam int AW = COORD_WIDTH + 28;
	localparam int MW = VW + 17;
	localparam int DW = AW + 16;

	localparam logic signed [VW-1:0] FAR_V  = VW'(vspc_pkg::FADE_FAR_Q8);
	localparam logic signed [VW-1:0] NEAR_V = VW'(vspc_pkg::FADE_NEAR_Q8);

	typedef enum logic [3:0] {
		S_IDLE, S_VMUL, S_VACC, S_FADE, S_FSTART, S_FWAIT, S_PMUL, S_PACC,
		S_CHECK, S_XSTART, S_XWAIT, S_YSTART, S_YWAIT, S_AMUL, S_OUT
	} state_t;

	state_t                   state_q;
	logic [1:0]               row_q;
	logic [1:0]               term_q;
	logic signed [COORD_WIDTH-1:0] pos_q [3];
	logic [15:0]              level_q;
	logic                     eop_q;
	logic signed [VW-1:0]     v_q [3];
	logic signed [AW-1:0]     c_q [4];
	logic signed [AW-1:0]     acc_q;
	logic signed [MW-1:0]     prod_q;
	logic signed [15:0]       qx_q;
	logic signed [15:0]       qy_q;
	logic                     path_open_q;
	logic                     res_valid_q;
	logic signed [15:0]       res_x_q;
	logic signed [15:0]       res_y_q;
	logic [15:0]              res_level_q;
	logic                     res_start_q;

	logic signed [16:0]       mul_a;
	logic signed [VW-1:0]     mul_b;
	logic signed [MW-1:0]     prod;
	logic [63:0]              vrow;
	logic [63:0]              prow;
	logic signed [AW-1:0]     acc_new;
	logic signed [AW-1:0]     vround;
	logic signed [AW-1:0]     vshift;
	logic signed [VW-1:0]     vnew;
	logic signed [AW-1:0]     clip_sel;
	logic [AW-1:0]            clip_abs;
	logic signed [AW-1:0]     neg_w;
	logic                     vis;
	logic                     div_start;
	logic [DW-1:0]            div_num;
	logic [DW-1:0]            div_den;
	vspc_pkg::div_stat_t      div_stat;
	logic [vspc_pkg::QUOT_W-1:0] div_quot;
	logic signed [15:0]       q_signed;
	logic signed [MW-1:0]     sx_round;
	logic signed [MW-1:0]     sx_full;
	logic signed [15:0]       sx_sat;
	logic                     res_load;

	always_comb begin
		case (row_q)
			2'd0:    vrow = cfg.view_x;
			2'd1:    vrow = cfg.view_y;
			default: vrow = cfg.view_z;
		endcase
		case (row_q)
			2'd0:    prow = cfg.proj_x;
			2'd1:    prow = cfg.proj_y;
			2'd2:    prow = cfg.proj_z;
			default: prow = cfg.proj_w;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_VMUL: begin
				mul_a = 17'(vspc_pkg::lane(vrow, term_q));
				mul_b = VW'(pos_q[term_q]);
			end
			S_FADE: begin
				mul_a = signed'({1'b0, level_q});
				mul_b = v_q[2] - FAR_V;
			end
			S_PMUL: begin
				mul_a = 17'(vspc_pkg::lane(prow, term_q));
				mul_b = (term_q == 2'd3) ? VW'(256) : v_q[term_q];
			end
			S_AMUL: begin
				mul_a = signed'({1'b0, cfg.aspect});
				mul_b = VW'(qx_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign acc_new = acc_q + AW'(prod_q);
	assign vround = acc_new + AW'(vspc_pkg::VIEW_ROUND);
	assign vshift = vround >>> vspc_pkg::VIEW_SHIFT;
	assign vnew = VW'(vshift) + (VW'(vspc_pkg::lane(vrow, 2'd3)) <<< 8);

	assign neg_w = -c_q[3];
	assign vis = (c_q[0] >= neg_w) && (c_q[0] <= c_q[3])
		&& (c_q[1] >= neg_w) && (c_q[1] <= c_q[3])
		&& (c_q[2] >= neg_w) && (c_q[2] <= c_q[3]);

	assign clip_sel = (state_q == S_YSTART) ? c_q[1] : c_q[0];
	assign clip_abs = clip_sel[AW-1] ? $unsigned(-clip_sel) : $unsigned(clip_sel);

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = DW'($unsigned(c_q[3]));
		case (state_q)
			S_FSTART: begin
				div_start = 1'b1;
				div_num = DW'($unsigned(prod_q));
				div_den = DW'(vspc_pkg::FADE_SPAN_Q8);
			end
			S_XSTART, S_YSTART: begin
				div_start = 1'b1;
				div_num = DW'({clip_abs, {vspc_pkg::DIV_SCALE_SH{1'b0}}});
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	vspc_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// Sign follows the clip coordinate; w is known positive here
	assign q_signed = (((state_q == S_YWAIT) ? c_q[1][AW-1] : c_q[0][AW-1]))
		? -signed'(div_quot) : signed'(div_quot);

	assign sx_round = prod_q + MW'(vspc_pkg::ASPECT_ROUND);
	assign sx_full = sx_round >>> vspc_pkg::ASPECT_SHIFT;
	always_comb begin
		if (sx_full > MW'(32767)) sx_sat = 16'sh7FFF;
		else if (sx_full < -MW'(32768)) sx_sat = -16'sh8000;
		else sx_sat = 16'(sx_full);
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign res_load = (state_q == S_OUT) && (!res_valid_q || result.ready);

	assign result.valid = res_valid_q;
	assign result.screen_x = res_x_q;
	assign result.screen_y = res_y_q;
	assign result.level_out = res_level_q;
	assign result.path_start = res_start_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q[0] <= q_pos_x;
				pos_q[1] <= q_pos_y;
				pos_q[2] <= q_pos_z;
				level_q <= q_level;
				eop_q <= q_eop;
				acc_q <= '0;
			end
			S_VMUL, S_PMUL: prod_q <= prod;
			S_VACC: begin
				if (term_q == 2'd2) begin
					v_q[row_q] <= vnew;
					acc_q <= '0;
				end else begin
					acc_q <= acc_new;
				end
			end
			S_FADE: begin
				prod_q <= prod;
				if (v_q[2] <= FAR_V) level_q <= '0;
			end
			S_FWAIT: if (div_stat.done) level_q <= div_quot;
			S_PACC: begin
				if (term_q == 2'd3) begin
					c_q[row_q] <= acc_new;
					acc_q <= '0;
				end else begin
					acc_q <= acc_new;
				end
			end
			S_CHECK: begin
				qx_q <= '0;
				qy_q <= '0;
			end
			S_XWAIT: if (div_stat.done) qx_q <= q_signed;
			S_YWAIT: if (div_stat.done) qy_q <= q_signed;
			S_AMUL: prod_q <= prod;
			default: begin
			end
		endcase
		if (res_load) begin
			res_x_q <= sx_sat;
			res_y_q <= qy_q;
			res_level_q <= level_q;
			res_start_q <= !path_open_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			term_q <= '0;
			path_open_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						row_q <= '0;
						term_q <= '0;
						if (q_blank) path_open_q <= 1'b0;
						else state_q <= S_VMUL;
					end
				end
				S_VMUL: state_q <= S_VACC;
				S_VACC: begin
					if (term_q == 2'd2) begin
						term_q <= '0;
						if (row_q == 2'd2) begin
							row_q <= '0;
							state_q <= S_FADE;
						end else begin
							row_q <= row_q + 1'b1;
							state_q <= S_VMUL;
						end
					end else begin
						term_q <= term_q + 1'b1;
						state_q <= S_VMUL;
					end
				end
				S_FADE: begin
					if (v_q[2] > FAR_V && v_q[2] < NEAR_V) state_q <= S_FSTART;
					else state_q <= S_PMUL;
				end
				S_FSTART: state_q <= S_FWAIT;
				S_FWAIT: if (div_stat.done) state_q <= S_PMUL;
				S_PMUL: state_q <= S_PACC;
				S_PACC: begin
					if (term_q == 2'd3) begin
						term_q <= '0;
						if (row_q == 2'd3) begin
							row_q <= '0;
							state_q <= S_CHECK;
						end else begin
							row_q <= row_q + 1'b1;
							state_q <= S_PMUL;
						end
					end else begin
						term_q <= term_q + 1'b1;
						state_q <= S_PMUL;
					end
				end
				S_CHECK: begin
					if (!vis) begin
						path_open_q <= 1'b0;
						state_q <= S_IDLE;
					end else if (c_q[3] == '0) begin
						state_q <= S_AMUL;
					end else begin
						state_q <= S_XSTART;
					end
				end
				S_XSTART: state_q <= S_XWAIT;
				S_XWAIT: if (div_stat.done) state_q <= S_YSTART;
				S_YSTART: state_q <= S_YWAIT;
				S_YWAIT: if (div_stat.done) state_q <= S_AMUL;
				S_AMUL: state_q <= S_OUT;
				S_OUT: begin
					if (res_load) begin
						path_open_q <= !eop_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || result.ready))
		else $error("result register overwritten");
	a_path_opens_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(path_open_q) |-> $past(res_load))
		else $error("path opened without a result");
`endif

endmodule
